@@ rtl/lsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsc_pkg
// Types and constants shared by the line segment clipper modules.
// ----------------------------------------------------------------------------
package lsc_pkg;

    // coordinate format and internal working width
    localparam int COORD_WIDTH = 32;
    localparam int IW          = 64;
    localparam int PW          = 2 * IW;
    localparam int HW          = IW / 2;
    localparam int DIV_STEPS   = PW;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int MAX_ROUNDS  = 4;
    localparam int RND_W       = $clog2(MAX_ROUNDS + 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [IW-1:0]          t_wide;

    // status codes
    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_CLIP   = 2'd2;

    // ignored axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // region code bits
    localparam int RC_LEFT   = 0;
    localparam int RC_RIGHT  = 1;
    localparam int RC_BOTTOM = 2;
    localparam int RC_TOP    = 3;

    typedef struct packed {
        logic [1:0] ignore_axis;
        t_coord     p1_x;
        t_coord     p1_y;
        t_coord     p1_z;
        t_coord     p2_x;
        t_coord     p2_y;
        t_coord     p2_z;
        t_coord     win_a_min;
        t_coord     win_a_max;
        t_coord     win_b_min;
        t_coord     win_b_max;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        t_coord     q1_x;
        t_coord     q1_y;
        t_coord     q1_z;
        t_coord     q2_x;
        t_coord     q2_y;
        t_coord     q2_z;
    } t_out;

    // controller commands to the datapath
    typedef struct packed {
        logic       load;
        logic       setup;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       div_en;
        logic       update;
        logic       out_wr;
        logic [1:0] status;
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic all_in;
        logic both_out;
        logic out_free;
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_UPD,
        S_OUT
    } t_state;

endpackage

@@ rtl/lsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer: region check, clip rounds (multiply, divide, endpoint update), output.
// ----------------------------------------------------------------------------
module lsc_ctrl import lsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [RND_W-1:0]   r_round, n_round;
    logic [1:0]         r_status, n_status;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_round  <= '0;
            r_status <= ST_INSIDE;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_round  <= n_round;
            r_status <= n_status;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_round  = r_round;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.mul_idx = r_cnt[1:0];
        o_cmd.status  = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.all_in) begin
                    n_status = (r_round == '0) ? ST_INSIDE : ST_CLIP;
                    n_state  = S_OUT;
                end else if (i_sts.both_out || r_round == RND_W'(MAX_ROUNDS)) begin
                    n_status = ST_REJECT;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_en = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_round      = r_round + 1'b1;
                n_state      = S_CHECK;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/lsc_dp.sv @@
// ----------------------------------------------------------------------------
// lsc_dp
// Clipper datapath: endpoints, region codes, shared multiplier and divider.
// ----------------------------------------------------------------------------
module lsc_dp import lsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_in              r_orig;
    t_wide            r_pa [2];
    t_wide            r_pb [2];
    t_wide            r_wamin, r_wamax, r_wbmin, r_wbmax;
    logic [3:0]       r_code [2];
    logic             r_sel, r_use_a, r_neg, r_zero;
    t_wide            r_edge, r_bv;
    logic [IW-1:0]    r_m1, r_m2, r_m3;
    logic [PW-1:0]    r_acc;
    logic [IW-1:0]    r_rem, r_q;
    t_out             r_out;
    logic             r_out_valid;

    function automatic logic [3:0] region(t_wide u, t_wide v, t_wide amin, t_wide amax,
                                          t_wide bmin, t_wide bmax);
        logic [3:0] c;
        c = '0;
        if (u < amin)      c[RC_LEFT]   = 1'b1;
        else if (u > amax) c[RC_RIGHT]  = 1'b1;
        if (v < bmin)      c[RC_BOTTOM] = 1'b1;
        else if (v > bmax) c[RC_TOP]    = 1'b1;
        return c;
    endfunction

    // input widening and axis selection
    t_wide l_p1x, l_p1y, l_p1z, l_p2x, l_p2y, l_p2z;
    t_wide l_wamin, l_wamax, l_wbmin, l_wbmax;
    t_wide l_a1, l_b1, l_a2, l_b2;
    always_comb begin
        l_p1x   = IW'(i_in.p1_x);
        l_p1y   = IW'(i_in.p1_y);
        l_p1z   = IW'(i_in.p1_z);
        l_p2x   = IW'(i_in.p2_x);
        l_p2y   = IW'(i_in.p2_y);
        l_p2z   = IW'(i_in.p2_z);
        l_wamin = IW'(i_in.win_a_min);
        l_wamax = IW'(i_in.win_a_max);
        l_wbmin = IW'(i_in.win_b_min);
        l_wbmax = IW'(i_in.win_b_max);
        case (i_in.ignore_axis)
            AXIS_X: begin
                l_a1 = l_p1z; l_b1 = l_p1y; l_a2 = l_p2z; l_b2 = l_p2y;
            end
            AXIS_Y: begin
                l_a1 = l_p1x; l_b1 = l_p1z; l_a2 = l_p2x; l_b2 = l_p2z;
            end
            default: begin
                l_a1 = l_p1x; l_b1 = l_p1y; l_a2 = l_p2x; l_b2 = l_p2y;
            end
        endcase
    end

    // round setup: pick endpoint and edge, form the magnitudes
    logic       l_sel, l_use_a, l_n1, l_n2, l_n3;
    logic [3:0] l_cc;
    t_wide      l_bu, l_bv, l_ou, l_ov, l_edge;
    logic [IW-1:0] l_m1, l_m2, l_m3;
    always_comb begin
        l_sel   = (r_code[0] == 4'd0);
        l_cc    = r_code[l_sel];
        l_use_a = l_cc[RC_LEFT] | l_cc[RC_RIGHT];
        if (l_use_a) begin
            l_bu = r_pa[0]; l_bv = r_pb[0]; l_ou = r_pa[1]; l_ov = r_pb[1];
            l_edge = l_cc[RC_LEFT] ? r_wamin : r_wamax;
        end else begin
            l_bu = r_pb[0]; l_bv = r_pa[0]; l_ou = r_pb[1]; l_ov = r_pa[1];
            l_edge = l_cc[RC_BOTTOM] ? r_wbmin : r_wbmax;
        end
        l_n1 = l_edge < l_bu;
        l_m1 = l_n1 ? IW'(l_bu - l_edge) : IW'(l_edge - l_bu);
        l_n2 = l_ov < l_bv;
        l_m2 = l_n2 ? IW'(l_bv - l_ov) : IW'(l_ov - l_bv);
        l_n3 = l_ou < l_bu;
        l_m3 = l_n3 ? IW'(l_bu - l_ou) : IW'(l_ou - l_bu);
    end

    // partial product of the shared multiplier
    logic [HW-1:0] l_x, l_y;
    logic [IW-1:0] l_pp;
    logic [PW-1:0] l_pp_sh;
    always_comb begin
        l_x  = i_cmd.mul_idx[0] ? r_m1[IW-1:HW] : r_m1[HW-1:0];
        l_y  = i_cmd.mul_idx[1] ? r_m2[IW-1:HW] : r_m2[HW-1:0];
        l_pp = IW'(l_x) * IW'(l_y);
        l_pp_sh = PW'(l_pp) << (HW * (32'(i_cmd.mul_idx[0]) + 32'(i_cmd.mul_idx[1])));
    end

    // restoring divide step
    logic [IW:0]   l_rem2;
    logic          l_take;
    always_comb begin
        l_rem2 = {r_rem, r_acc[PW-1]};
        l_take = l_rem2 >= {1'b0, r_m3};
    end

    // endpoint update
    t_wide      l_qs, l_res, l_na, l_nb;
    always_comb begin
        l_qs  = r_neg ? -$signed(r_q) : $signed(r_q);
        l_res = r_zero ? r_bv : r_bv + l_qs;
        l_na  = r_use_a ? r_edge : l_res;
        l_nb  = r_use_a ? l_res : r_edge;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_orig    <= i_in;
            r_pa[0]   <= l_a1;
            r_pb[0]   <= l_b1;
            r_pa[1]   <= l_a2;
            r_pb[1]   <= l_b2;
            r_wamin   <= l_wamin;
            r_wamax   <= l_wamax;
            r_wbmin   <= l_wbmin;
            r_wbmax   <= l_wbmax;
            r_code[0] <= region(l_a1, l_b1, l_wamin, l_wamax, l_wbmin, l_wbmax);
            r_code[1] <= region(l_a2, l_b2, l_wamin, l_wamax, l_wbmin, l_wbmax);
        end
        if (i_cmd.setup) begin
            r_sel   <= l_sel;
            r_use_a <= l_use_a;
            r_edge  <= l_edge;
            r_bv    <= l_bv;
            r_m1    <= l_m1;
            r_m2    <= l_m2;
            r_m3    <= l_m3;
            r_neg   <= l_n1 ^ l_n2 ^ l_n3;
            r_zero  <= (l_m3 == '0);
            r_acc   <= '0;
            r_rem   <= '0;
            r_q     <= '0;
        end
        if (i_cmd.mul_en) begin
            r_acc <= r_acc + l_pp_sh;
        end
        if (i_cmd.div_en) begin
            r_acc <= {r_acc[PW-2:0], 1'b0};
            r_rem <= l_take ? IW'(l_rem2 - {1'b0, r_m3}) : l_rem2[IW-1:0];
            r_q   <= {r_q[IW-2:0], l_take};
        end
        if (i_cmd.update) begin
            r_pa[r_sel]   <= l_na;
            r_pb[r_sel]   <= l_nb;
            r_code[r_sel] <= region(l_na, l_nb, r_wamin, r_wamax, r_wbmin, r_wbmax);
        end
    end

    // rebuild the result endpoints
    t_out l_out;
    always_comb begin
        l_out        = '0;
        l_out.status = i_cmd.status;
        l_out.q1_x   = r_orig.p1_x;
        l_out.q1_y   = r_orig.p1_y;
        l_out.q1_z   = r_orig.p1_z;
        l_out.q2_x   = r_orig.p2_x;
        l_out.q2_y   = r_orig.p2_y;
        l_out.q2_z   = r_orig.p2_z;
        if (i_cmd.status == ST_CLIP) begin
            case (r_orig.ignore_axis)
                AXIS_X: begin
                    l_out.q1_z = r_pa[0][COORD_WIDTH-1:0];
                    l_out.q1_y = r_pb[0][COORD_WIDTH-1:0];
                    l_out.q2_z = r_pa[1][COORD_WIDTH-1:0];
                    l_out.q2_y = r_pb[1][COORD_WIDTH-1:0];
                end
                AXIS_Y: begin
                    l_out.q1_x = r_pa[0][COORD_WIDTH-1:0];
                    l_out.q1_z = r_pb[0][COORD_WIDTH-1:0];
                    l_out.q2_x = r_pa[1][COORD_WIDTH-1:0];
                    l_out.q2_z = r_pb[1][COORD_WIDTH-1:0];
                end
                default: begin
                    l_out.q1_x = r_pa[0][COORD_WIDTH-1:0];
                    l_out.q1_y = r_pb[0][COORD_WIDTH-1:0];
                    l_out.q2_x = r_pa[1][COORD_WIDTH-1:0];
                    l_out.q2_y = r_pb[1][COORD_WIDTH-1:0];
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_wr) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) begin
            r_out <= l_out;
        end
    end

    assign o_sts.all_in   = (r_code[0] == 4'd0) && (r_code[1] == 4'd0);
    assign o_sts.both_out = ((r_code[0] & r_code[1]) != 4'd0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

endmodule

@@ rtl/line_segment_clipper_unit.sv @@
// a segment fully inside or trivially rejected goes from the region check to the
// output; a clipped segment runs at most 4 clip rounds (multiply, divide, update)
// one segment at a time; the divider, one quotient bit per cycle, is the longest step
// the next segment is taken while a finished result waits in the output register
// reset: synchronous, active low; clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// line_segment_clipper_unit
// Cohen-Sutherland clipper of a 3D segment against a 2D window on two axes.
// ----------------------------------------------------------------------------
module line_segment_clipper_unit import lsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    // sequencer
    lsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_busy     (w_busy),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    lsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    assign o_in_stall = w_busy;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line segment clipper: directed and random
// segments against a built-in clipping predictor, random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import lsc_pkg::*;

    localparam logic [1:0] AXIS_Z = 2'd2;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    t_out expected_q[$];
    int   error_count;
    int   hold_cycles;
    bit   stall_random;

    line_segment_clipper_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // interpolated coordinate at u = edge on the line (bu,bv)-(ou,ov)
    function automatic longint interp_coord(longint bu, longint bv, longint ou,
                                            longint ov, longint edg);
        logic [63:0]  du, dv, dd;
        logic [127:0] prod, quo;
        bit           neg;
        longint       res;
        du = (edg > bu) ? edg - bu : bu - edg;
        dv = (ov > bv) ? ov - bv : bv - ov;
        dd = (ou > bu) ? ou - bu : bu - ou;
        if (dd == 0) return bv;
        neg = (edg < bu) ^ (ov < bv) ^ (ou < bu);
        prod = {64'd0, du} * {64'd0, dv};
        quo = prod / {64'd0, dd};
        res = neg ? bv - longint'(quo[63:0]) : bv + longint'(quo[63:0]);
        return res;
    endfunction

    function automatic logic [3:0] clip_code(longint u, longint v, longint w[4]);
        logic [3:0] c;
        c = '0;
        if (u < w[0]) c[RC_LEFT] = 1'b1;
        else if (u > w[1]) c[RC_RIGHT] = 1'b1;
        if (v < w[2]) c[RC_BOTTOM] = 1'b1;
        else if (v > w[3]) c[RC_TOP] = 1'b1;
        return c;
    endfunction

    // clipped segment for one transaction
    function automatic t_out clip_segment(t_in s);
        longint     p[2][3];
        longint     w[4];
        logic [3:0] c[2];
        logic [3:0] cc;
        int         a, b, sel;
        longint     qa, qb;
        t_out       r;
        p[0][0] = s.p1_x; p[0][1] = s.p1_y; p[0][2] = s.p1_z;
        p[1][0] = s.p2_x; p[1][1] = s.p2_y; p[1][2] = s.p2_z;
        w[0] = s.win_a_min; w[1] = s.win_a_max;
        w[2] = s.win_b_min; w[3] = s.win_b_max;
        if (s.ignore_axis == AXIS_X) begin
            a = 2; b = 1;
        end else if (s.ignore_axis == AXIS_Y) begin
            a = 0; b = 2;
        end else begin
            a = 0; b = 1;
        end
        c[0] = clip_code(p[0][a], p[0][b], w);
        c[1] = clip_code(p[1][a], p[1][b], w);
        r = '{ST_REJECT, s.p1_x, s.p1_y, s.p1_z, s.p2_x, s.p2_y, s.p2_z};
        if (c[0] == 0 && c[1] == 0) begin
            r.status = ST_INSIDE;
            return r;
        end
        for (int rnd = 0; rnd < MAX_ROUNDS; rnd++) begin
            if (c[0] == 0 && c[1] == 0) break;
            if ((c[0] & c[1]) != 0) break;
            sel = (c[0] != 0) ? 0 : 1;
            cc = c[sel];
            if (cc[RC_LEFT] || cc[RC_RIGHT]) begin
                qa = cc[RC_LEFT] ? w[0] : w[1];
                qb = interp_coord(p[0][a], p[0][b], p[1][a], p[1][b], qa);
            end else begin
                qb = cc[RC_BOTTOM] ? w[2] : w[3];
                qa = interp_coord(p[0][b], p[0][a], p[1][b], p[1][a], qb);
            end
            p[sel][a] = qa;
            p[sel][b] = qb;
            c[sel] = clip_code(qa, qb, w);
        end
        if (c[0] == 0 && c[1] == 0) begin
            r = '{ST_CLIP, t_coord'(p[0][0]), t_coord'(p[0][1]), t_coord'(p[0][2]),
                  t_coord'(p[1][0]), t_coord'(p[1][1]), t_coord'(p[1][2])};
        end
        return r;
    endfunction

    // random gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one segment and queue its expected result
    task automatic send_segment(t_in s, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        @(negedge i_clk);
        repeat (g) @(negedge i_clk);
        i_in <= s;
        i_in_valid <= 1'b1;
        expected_q.push_back(clip_segment(s));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result status=%0d", o_out.status);
                error_count++;
            end else begin
                t_out e;
                e = expected_q.pop_front();
                if (e.status !== o_out.status) begin
                    $error("status exp %0d got %0d", e.status, o_out.status); error_count++;
                end
                if (e.q1_x !== o_out.q1_x) begin
                    $error("q1_x exp %0d got %0d", e.q1_x, o_out.q1_x); error_count++;
                end
                if (e.q1_y !== o_out.q1_y) begin
                    $error("q1_y exp %0d got %0d", e.q1_y, o_out.q1_y); error_count++;
                end
                if (e.q1_z !== o_out.q1_z) begin
                    $error("q1_z exp %0d got %0d", e.q1_z, o_out.q1_z); error_count++;
                end
                if (e.q2_x !== o_out.q2_x) begin
                    $error("q2_x exp %0d got %0d", e.q2_x, o_out.q2_x); error_count++;
                end
                if (e.q2_y !== o_out.q2_y) begin
                    $error("q2_y exp %0d got %0d", e.q2_y, o_out.q2_y); error_count++;
                end
                if (e.q2_z !== o_out.q2_z) begin
                    $error("q2_z exp %0d got %0d", e.q2_z, o_out.q2_z); error_count++;
                end
            end
        end
    end

    // receiver stall: a long hold-off when requested, else random gaps
    initial begin
        int g;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (stall_random && !i_out_stall) begin
                g = gap_len();
                if (g > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (g) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // coordinate generator: extremes, small values and full random
    function automatic t_coord rand_coord(int scale);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'sh7fffffff;
        if (r < 6) return 32'sh80000000;
        if (r < 15) return t_coord'($urandom);
        return t_coord'($signed($urandom_range(0, 2 * scale)) - scale);
    endfunction

    function automatic t_in rand_segment();
        t_in    s;
        t_coord t0, t1;
        int     sc;
        sc = ($urandom_range(0, 3) == 0) ? 32'h3fffffff : 32'h000a0000;
        s.ignore_axis = 2'($urandom_range(0, 3));
        s.p1_x = rand_coord(sc); s.p1_y = rand_coord(sc); s.p1_z = rand_coord(sc);
        s.p2_x = rand_coord(sc); s.p2_y = rand_coord(sc); s.p2_z = rand_coord(sc);
        t0 = rand_coord(sc / 2); t1 = rand_coord(sc / 2);
        // mostly well-formed windows, sometimes inverted
        if ($urandom_range(0, 9) != 0 && t0 > t1) begin
            s.win_a_min = t1; s.win_a_max = t0;
        end else begin
            s.win_a_min = t0; s.win_a_max = t1;
        end
        t0 = rand_coord(sc / 2); t1 = rand_coord(sc / 2);
        if ($urandom_range(0, 9) != 0 && t0 > t1) begin
            s.win_b_min = t1; s.win_b_max = t0;
        end else begin
            s.win_b_min = t0; s.win_b_max = t1;
        end
        // occasional vertical or horizontal lines
        if ($urandom_range(0, 9) == 0) s.p2_x = s.p1_x;
        if ($urandom_range(0, 9) == 0) s.p2_y = s.p1_y;
        if ($urandom_range(0, 9) == 0) s.p2_z = s.p1_z;
        return s;
    endfunction

    function automatic t_in mk(logic [1:0] ax, int x1, int y1, int x2, int y2,
                               int amin, int amax, int bmin, int bmax);
        t_in s;
        s = '{ax, x1, y1, 32'sh00050000, x2, y2, -32'sh00030000,
              amin, amax, bmin, bmax};
        return s;
    endfunction

    // directed cases: inside, rejected, clipped on each edge, degenerate lines
    task automatic test_directed();
        localparam int U = 32'h10000;
        send_segment(mk(AXIS_Z, 1*U, 1*U, 2*U, 2*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, -5*U, 1*U, -3*U, 2*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, -2*U, 1*U, 2*U, 3*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, 2*U, 1*U, 7*U, 3*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, 1*U, -3*U, 3*U, 2*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, 1*U, 2*U, 3*U, 9*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, -3*U, -2*U, 8*U, 9*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, -3*U, 5*U, 1*U, 9*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, 2*U, -3*U, 2*U, 9*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, -3*U, 2*U, 9*U, 2*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, 1*U, 1*U, 2*U, 2*U, 4*U, 0, 0, 4*U), 0);
        send_segment(mk(AXIS_X, 1*U, 1*U, 2*U, 2*U, -9*U, 0, 0, 4*U), 0);
        send_segment(mk(AXIS_Y, -2*U, 1*U, 2*U, 3*U, 0, 4*U, -4*U, 9*U), 0);
        send_segment(mk(2'd3, -2*U, 1*U, 2*U, 3*U, 0, 4*U, 0, 4*U), 0);
        send_segment(mk(AXIS_Z, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                        32'sh7fffffff, -U, U, -U, U), 0);
        send_segment(mk(AXIS_Z, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                        32'sh80000000, 32'sh7fffffff), 0);
        send_segment('1, 0);
        send_segment('0, 0);
        wait_drained();
    endtask

    // random segments with gaps on both sides
    task automatic test_random(int n);
        stall_random = 1'b1;
        repeat (n) send_segment(rand_segment(), 1);
        wait_drained();
        stall_random = 1'b0;
    endtask

    // receiver holds off long enough to back up the input
    task automatic test_backpressure();
        hold_cycles = 2000;
        repeat (6) send_segment(rand_segment(), 0);
        wait_drained();
    endtask

    initial begin
        error_count = 0;
        hold_cycles = 0;
        stall_random = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random(800);
        test_random(800);
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("line_segment_clipper_unit: match");
        else
            $display("line_segment_clipper_unit: mismatch");
        $finish;
    end

    // run time limit
    initial begin
        #100ms;
        $display("line_segment_clipper_unit: mismatch");
        $finish;
    end

endmodule

@@ line_segment_clipper_unit.f @@
rtl/lsc_pkg.sv
rtl/lsc_ctrl.sv
rtl/lsc_dp.sv
rtl/line_segment_clipper_unit.sv
test/testbench.sv
